FILE: design/nfba_pkg.sv
package nfba_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int WORD_W      = 64;
  localparam int OFF_W       = $clog2(WORD_W);
  localparam int ROWS        = MAX_ENTRIES / WORD_W;
  localparam int ROW_W       = IDX_W - OFF_W;
  localparam int VIS_W       = ROW_W + 1;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    logic             failed;
    logic             entry_used;
    logic [CNT_W-1:0] used_total;
  } rsp_t;

  // Per-word qualification for the allocate search
  typedef struct packed {
    logic             is_first;   // first visit of start word: bits at/above start offset
    logic             is_final;   // revisit of start word: bits below start offset
    logic [OFF_W-1:0] s_off;
    logic             is_wlast;   // word holds the top of the active range
    logic [OFF_W-1:0] lim_off;
    logic             skip_last;  // word holds the last allocated position
    logic [OFF_W-1:0] last_off;
  } scan_ctl_t;

endpackage

FILE: design/nfba_scan.sv
module nfba_scan import nfba_pkg::*; (
  input  logic [WORD_W-1:0] word_i,
  input  scan_ctl_t         ctl_i,
  output logic              found_o,
  output logic [OFF_W-1:0]  off_o
);

  logic [WORD_W-1:0] free_bits;
  logic [WORD_W-1:0] iso_bits;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      free_bits[b] = ~word_i[b];
      if (ctl_i.is_wlast && (OFF_W'(b) > ctl_i.lim_off)) begin
        free_bits[b] = 1'b0;
      end
      if (ctl_i.skip_last && (OFF_W'(b) == ctl_i.last_off)) begin
        free_bits[b] = 1'b0;
      end
      if (ctl_i.is_first && (OFF_W'(b) < ctl_i.s_off)) begin
        free_bits[b] = 1'b0;
      end
      if (ctl_i.is_final && (OFF_W'(b) >= ctl_i.s_off)) begin
        free_bits[b] = 1'b0;
      end
    end
  end

  // lowest set bit isolated, then encoded
  assign iso_bits = free_bits & (~free_bits + WORD_W'(1));
  assign found_o  = |free_bits;

  always_comb begin
    off_o = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (iso_bits[b]) begin
        off_o = off_o | OFF_W'(b);
      end
    end
  end

endmodule

FILE: design/next_fit_bitmap_allocator_top.sv
// Channel   Handshake            Payload      Width
// request   start / busy         req_i        mode 2, index 12
// result    done_o (strobe)      rsp_o        granted 12, failed 1, used 1, total 13
// config    cfg_we_i             cfg_wdata_i  size 13
//
// Allocate: checks 64-bit words one after another, one word per cycle, limited by the
// single read port of the bitmap RAM. Free and query: one RAM read, then write-back when
// a used entry is freed. Bad requests are answered straight from idle.
// Reset is immediate: per-row valid flops make unwritten rows read as free.
// done_o pulses for one cycle; busy is high while a request is being worked on.
module next_fit_bitmap_allocator_top import nfba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  size_q;
  logic [IDX_W-1:0]  last_pos_q, last_pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ROWS-1:0]   row_vld_q;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  logic [1:0]        mode_q;
  logic [IDX_W-1:0]  idx_q;
  logic [OFF_W-1:0]  s_off_q;
  logic [ROW_W-1:0]  chk_w_q, chk_w_d;
  logic [VIS_W-1:0]  chk_v_q, chk_v_d;
  logic [ROW_W-1:0]  rd_row_q;

  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] rdata_q;
  logic [WORD_W-1:0] rdata_eff;
  logic              mem_we;
  logic [ROW_W-1:0]  mem_wa;
  logic [WORD_W-1:0] mem_wd;
  logic [ROW_W-1:0]  mem_ra;

  logic [CNT_W-1:0]  size_eff;
  logic [CNT_W-1:0]  size_m1;
  logic [ROW_W-1:0]  wlast;
  logic [VIS_W-1:0]  nwords;
  logic              last_in;
  logic [CNT_W-1:0]  lp1;
  logic [IDX_W-1:0]  s_pos;
  logic [ROW_W-1:0]  nxt_w;
  logic              accept;
  logic              idx_bad;

  scan_ctl_t         scan_ctl;
  logic              scan_found;
  logic [OFF_W-1:0]  scan_off;
  logic              acc_bit;

  // active size, clamped to 1..MAX_ENTRIES
  always_comb begin
    size_eff = size_q;
    if (size_q == '0) begin
      size_eff = CNT_W'(1);
    end else if (size_q > CNT_W'(MAX_ENTRIES)) begin
      size_eff = CNT_W'(MAX_ENTRIES);
    end
  end

  assign size_m1 = size_eff - CNT_W'(1);
  assign wlast   = size_m1[IDX_W-1:OFF_W];
  assign nwords  = {1'b0, wlast} + VIS_W'(1);
  assign last_in = {1'b0, last_pos_q} < size_eff;
  assign lp1     = {1'b0, last_pos_q} + CNT_W'(1);
  assign s_pos   = (lp1 >= size_eff) ? '0 : lp1[IDX_W-1:0];
  assign nxt_w   = (chk_w_q == wlast) ? '0 : chk_w_q + ROW_W'(1);
  assign accept  = start && !busy;
  assign idx_bad = {1'b0, req_i.index} >= size_eff;

  assign busy    = state_q != ST_IDLE;
  assign done_o  = done_q;
  assign rsp_o   = rsp_q;

  // rows never written since reset read as all free
  assign rdata_eff = row_vld_q[rd_row_q] ? rdata_q : '0;
  assign acc_bit   = rdata_eff[idx_q[OFF_W-1:0]];

  always_comb begin
    scan_ctl.is_first  = chk_v_q == '0;
    scan_ctl.is_final  = chk_v_q == nwords;
    scan_ctl.s_off     = s_off_q;
    scan_ctl.is_wlast  = chk_w_q == wlast;
    scan_ctl.lim_off   = size_m1[OFF_W-1:0];
    scan_ctl.skip_last = last_in && (last_pos_q[IDX_W-1:OFF_W] == chk_w_q);
    scan_ctl.last_off  = last_pos_q[OFF_W-1:0];
  end

  nfba_scan u_scan (
    .word_i  (rdata_eff),
    .ctl_i   (scan_ctl),
    .found_o (scan_found),
    .off_o   (scan_off)
  );

  always_comb begin
    state_d    = state_q;
    last_pos_d = last_pos_q;
    cnt_d      = cnt_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    chk_w_d    = chk_w_q;
    chk_v_d    = chk_v_q;
    mem_we     = 1'b0;
    mem_wa     = chk_w_q;
    mem_wd     = rdata_eff;
    mem_ra     = nxt_w;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rsp_d = '{granted_index: '0, failed: 1'b1, entry_used: 1'b0, used_total: cnt_q};
          case (req_i.mode)
            MODE_ALLOC: begin
              mem_ra  = s_pos[IDX_W-1:OFF_W];
              chk_w_d = s_pos[IDX_W-1:OFF_W];
              chk_v_d = '0;
              state_d = ST_SCAN;
            end
            MODE_FREE, MODE_QUERY: begin
              mem_ra = req_i.index[IDX_W-1:OFF_W];
              if (idx_bad) begin
                done_d = 1'b1;
              end else begin
                state_d = ST_ACC;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // next word is already being read while this one is checked
        chk_w_d = nxt_w;
        chk_v_d = chk_v_q + VIS_W'(1);
        if (scan_found) begin
          mem_we     = 1'b1;
          mem_wa     = chk_w_q;
          mem_wd     = rdata_eff | (WORD_W'(1) << scan_off);
          last_pos_d = {chk_w_q, scan_off};
          cnt_d      = cnt_q + CNT_W'(1);
          rsp_d      = '{granted_index: {chk_w_q, scan_off}, failed: 1'b0,
                         entry_used: 1'b0, used_total: cnt_q + CNT_W'(1)};
          done_d     = 1'b1;
          state_d    = ST_IDLE;
        end else if (chk_v_q == nwords) begin
          rsp_d   = '{granted_index: '0, failed: 1'b1, entry_used: 1'b0, used_total: cnt_q};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_ACC: begin
        rsp_d = '{granted_index: '0, failed: 1'b0, entry_used: 1'b0, used_total: cnt_q};
        if (mode_q == MODE_QUERY) begin
          rsp_d.entry_used = acc_bit;
        end else if (acc_bit) begin
          mem_we           = 1'b1;
          mem_wa           = idx_q[IDX_W-1:OFF_W];
          mem_wd           = rdata_eff & ~(WORD_W'(1) << idx_q[OFF_W-1:0]);
          cnt_d            = cnt_q - CNT_W'(1);
          rsp_d.used_total = cnt_q - CNT_W'(1);
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      size_q     <= CNT_W'(MAX_ENTRIES);
      last_pos_q <= '0;
      cnt_q      <= '0;
      row_vld_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      last_pos_q <= last_pos_d;
      cnt_q      <= cnt_d;
      done_q     <= done_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (mem_we) begin
        row_vld_q[mem_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q    <= rsp_d;
    chk_w_q  <= chk_w_d;
    chk_v_q  <= chk_v_d;
    rd_row_q <= mem_ra;
    if (accept) begin
      mode_q  <= req_i.mode;
      idx_q   <= req_i.index;
      s_off_q <= s_pos[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

endmodule

FILE: design/nfba_chk.sv
module nfba_chk import nfba_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  // an accepted request either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request neither busy nor answered");

  // a result only ever follows a request
  a_done_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result without request");

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.failed) |-> (rsp_o.granted_index == '0 && !rsp_o.entry_used))
    else $error("failed result carries data");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.used_total <= CNT_W'(MAX_ENTRIES)))
    else $error("used total out of range");

endmodule

bind next_fit_bitmap_allocator_top nfba_chk u_nfba_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

FILE: test/tb_next_fit_bitmap_allocator_top.sv
`timescale 1ns / 100ps

module tb_next_fit_bitmap_allocator_top import nfba_pkg::*; ();

  localparam logic [1:0] MODE_UNDEF = 2'd3;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  req_t             req_i       = '0;
  logic             done_o;
  rsp_t             rsp_o;
  logic             cfg_we_i    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  // Shadow of the allocator state
  bit               alloc_map [MAX_ENTRIES];
  int               last_grant   = 0;
  int               used_entries = 0;
  logic [CNT_W-1:0] size_reg     = CNT_W'(4096);

  rsp_t rsp_due_q [$];
  rsp_t rsp_head;
  int   fail_count = 0;
  int   items_sent = 0;
  bit   idle_on    = 1'b1;

  next_fit_bitmap_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int active_entries(logic [CNT_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(n);
  endfunction

  // Next-fit allocation; the last granted slot is never revisited
  function automatic rsp_t allocator_answer(req_t r);
    rsp_t o;
    int   eff;
    int   pos;
    o   = '0;
    eff = active_entries(size_reg);
    case (r.mode)
      MODE_ALLOC: begin
        o.failed = 1'b1;
        pos      = last_grant + 1;
        for (int k = 0; k < eff; k++) begin
          if (pos >= eff) pos = 0;
          if (pos == last_grant) break;
          if (!alloc_map[pos]) begin
            alloc_map[pos]  = 1'b1;
            used_entries++;
            last_grant      = pos;
            o.granted_index = pos[IDX_W-1:0];
            o.failed        = 1'b0;
            break;
          end
          pos++;
        end
      end
      MODE_FREE: begin
        if (r.index >= eff) begin
          o.failed = 1'b1;
        end else if (alloc_map[r.index]) begin
          alloc_map[r.index] = 1'b0;
          used_entries--;
        end
      end
      MODE_QUERY: begin
        if (r.index >= eff) o.failed = 1'b1;
        else                o.entry_used = alloc_map[r.index];
      end
      default: o.failed = 1'b1;
    endcase
    o.used_total = used_entries[CNT_W-1:0];
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (rsp_due_q.size() == 0) begin
        $error("unexpected result: granted_index %0d failed %0b", rsp_o.granted_index,
               rsp_o.failed);
        fail_count++;
      end else begin
        rsp_head = rsp_due_q.pop_front();
        if (rsp_o.granted_index !== rsp_head.granted_index) begin
          $error("granted_index: expected %0d, actual %0d", rsp_head.granted_index,
                 rsp_o.granted_index);
          fail_count++;
        end
        if (rsp_o.failed !== rsp_head.failed) begin
          $error("failed: expected %0b, actual %0b", rsp_head.failed, rsp_o.failed);
          fail_count++;
        end
        if (rsp_o.entry_used !== rsp_head.entry_used) begin
          $error("entry_used: expected %0b, actual %0b", rsp_head.entry_used,
                 rsp_o.entry_used);
          fail_count++;
        end
        if (rsp_o.used_total !== rsp_head.used_total) begin
          $error("used_total: expected %0d, actual %0d", rsp_head.used_total,
                 rsp_o.used_total);
          fail_count++;
        end
      end
    end
  end

  // Entered at a falling edge; returns at a falling edge with start possibly still high
  task automatic send_req(input logic [1:0] mode, input logic [IDX_W-1:0] idx);
    req_t r;
    int   gap;
    r.mode  = mode;
    r.index = idx;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    rsp_due_q.push_back(allocator_answer(r));
    items_sent++;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (rsp_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_size(input int n);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n[CNT_W-1:0];
    @(posedge clk_i);
    size_reg = n[CNT_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_index(int eff);
    int roll;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      // close behind the allocation pointer, where used entries sit
      v = last_grant - int'($urandom_range(0, 12));
      if (v < 0) v = 0;
      if (v >= eff) v = $urandom_range(0, eff - 1);
    end else if (roll < 85) begin
      v = $urandom_range(0, eff - 1);
    end else if (roll < 92) begin
      v = (eff < MAX_ENTRIES) ? eff : MAX_ENTRIES - 1;
    end else begin
      v = $urandom_range(0, MAX_ENTRIES - 1);
    end
    return v[IDX_W-1:0];
  endfunction

  task automatic test_after_reset();
    send_req(MODE_QUERY, '0);
    send_req(MODE_QUERY, '1);
    send_req(MODE_FREE, IDX_W'(5));      // freeing a free entry
    send_req(MODE_UNDEF, '1);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_ALLOC, '1);
  endtask

  task automatic test_tiny_sizes();
    write_size(1);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_QUERY, '0);
    send_req(MODE_QUERY, IDX_W'(1));
    write_size(0);                       // behaves as one entry
    send_req(MODE_ALLOC, '0);
    write_size(2);                       // pointer now inside size
    send_req(MODE_ALLOC, '0);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_FREE, IDX_W'(1));
    send_req(MODE_ALLOC, '0);
    send_req(MODE_FREE, IDX_W'(1));      // only the pointer slot is free
    send_req(MODE_ALLOC, '0);
    send_req(MODE_FREE, '1);
    send_req(MODE_QUERY, IDX_W'(2));     // still counted above size
  endtask

  task automatic test_size_clamp();
    write_size(8191);
    send_req(MODE_QUERY, '1);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_FREE, IDX_W'(2));
    write_size(4097);
    send_req(MODE_ALLOC, '0);
  endtask

  task automatic test_random_traffic();
    int         n;
    int         roll;
    int         alloc_pct;
    int         free_pct;
    logic [1:0] m;
    while (items_sent < 750) begin
      roll = $urandom_range(0, 99);
      if      (roll < 25) n = $urandom_range(0, 8);
      else if (roll < 65) n = $urandom_range(9, 300);
      else if (roll < 80) n = 63 + $urandom_range(0, 2) + 64 * $urandom_range(0, 1);
      else if (roll < 90) n = $urandom_range(301, 4096);
      else                n = $urandom_range(4096, 8191);
      write_size(n);
      alloc_pct = $urandom_range(25, 80);
      free_pct  = $urandom_range(10, 95 - alloc_pct);
      idle_on   = (items_sent < 640) && ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(15, 50)) begin
        roll = $urandom_range(0, 99);
        if      (roll < alloc_pct)            m = MODE_ALLOC;
        else if (roll < alloc_pct + free_pct) m = MODE_FREE;
        else if (roll < 97)                   m = MODE_QUERY;
        else                                  m = MODE_UNDEF;
        send_req(m, pick_index(active_entries(size_reg)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_after_reset();
    test_tiny_sizes();
    test_size_clamp();
    test_random_traffic();
    wait_for_results();
    repeat (70) @(posedge clk_i);
    if (fail_count == 0 && rsp_due_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
design/nfba_pkg.sv
design/nfba_scan.sv
design/next_fit_bitmap_allocator_top.sv
design/nfba_chk.sv
test/tb_next_fit_bitmap_allocator_top.sv
